@@ design/kdsl_pkg.sv @@
`default_nettype none
package kdsl_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned PHASE_W  = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;

  // item codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // latched event codes
  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_ms;
    logic              key_pressed;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] key_event;
    logic [PHASE_W-1:0] fsm_phase;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage
`default_nettype wire

@@ design/key_debounce_short_long_press_top.sv @@
`default_nettype none
// channel  direction  handshake            payload
// in       sink       in_valid / in_ready  func, now_ms, key_pressed
// out      source     out_valid/ out_ready key_event, fsm_phase
// cfg      sink       cfg_we               cfg_index, cfg_data
//
// one beat per cycle in both directions unless out_ready stalls the output; an
// input beat goes to the input register, then the phase update to the result register
// the phase machine and timestamps advance only when a beat moves into the
// result register, so a stalled output holds the state as well
// reset brings back idle phase, no pending event and the default times
module key_debounce_short_long_press_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            func,
  input  wire logic [kdsl_pkg::TIME_W-1:0]     now_ms,
  input  wire logic                            key_pressed,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [kdsl_pkg::EVENT_W-1:0]         key_event,
  output logic [kdsl_pkg::PHASE_W-1:0]         fsm_phase,
  input  wire logic                            cfg_we,
  input  wire logic [kdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kdsl_pkg::CFG_W-1:0]      cfg_data
);
  import kdsl_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  result_t out_res;
  result_t core_res;
  cfg_wr_t cfg;
  logic    out_free;
  logic    step;

  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  kdsl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (s1_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.func        <= func;
      s1_item.now_ms      <= now_ms;
      s1_item.key_pressed <= key_pressed;
    end
    if (step) begin
      out_res <= core_res;
    end
  end

  assign key_event = out_res.key_event;
  assign fsm_phase = out_res.fsm_phase;

endmodule
`default_nettype wire

@@ design/kdsl_core.sv @@
`default_nettype none
module kdsl_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire kdsl_pkg::cfg_wr_t cfg,
  input  wire logic             step,
  input  wire kdsl_pkg::item_t  item,
  output kdsl_pkg::result_t     res
);
  import kdsl_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_WAIT     = 2'd3
  } phase_t;

  logic [CFG_W-1:0]   debounce_time;
  logic [CFG_W-1:0]   long_press_time;
  phase_t             phase;
  logic [TIME_W-1:0]  debounce_start;
  logic [TIME_W-1:0]  press_start;
  logic [EVENT_W-1:0] pending_event;

  phase_t             phase_next;
  logic [TIME_W-1:0]  debounce_start_next;
  logic [TIME_W-1:0]  press_start_next;
  logic [EVENT_W-1:0] pending_event_next;
  logic [EVENT_W-1:0] key_event_next;

  logic [TIME_W-1:0]  start_sel;
  logic [CFG_W-1:0]   limit_sel;
  logic [TIME_W-1:0]  elapsed;
  logic               expired;

  // one wrapping subtract shared by debounce and long-press timing
  assign start_sel = (phase == PH_DEBOUNCE) ? debounce_start : press_start;
  assign limit_sel = (phase == PH_DEBOUNCE) ? debounce_time : long_press_time;
  assign elapsed   = item.now_ms - start_sel;
  assign expired   = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, limit_sel});

  always_comb begin
    phase_next          = phase;
    debounce_start_next = debounce_start;
    press_start_next    = press_start;
    pending_event_next  = pending_event;
    key_event_next      = EV_NONE;
    if (item.func == FUNC_READ) begin
      key_event_next     = pending_event;
      pending_event_next = EV_NONE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (item.key_pressed) begin
            debounce_start_next = item.now_ms;
            phase_next          = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (!item.key_pressed) begin
            phase_next = PH_IDLE;
          end else if (expired) begin
            press_start_next = item.now_ms;
            phase_next       = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (!item.key_pressed) begin
            pending_event_next = EV_SHORT;
            phase_next         = PH_IDLE;
          end else if (expired) begin
            pending_event_next = EV_LONG;
            phase_next         = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!item.key_pressed) begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  assign res.key_event = key_event_next;
  assign res.fsm_phase = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_TIME_RST;
      long_press_time <= LONG_PRESS_TIME_RST;
      phase           <= PH_IDLE;
      debounce_start  <= '0;
      press_start     <= '0;
      pending_event   <= EV_NONE;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          REG_DEBOUNCE_TIME:   debounce_time   <= cfg.data;
          REG_LONG_PRESS_TIME: long_press_time <= cfg.data;
          default: ;
        endcase
      end
      if (step) begin
        phase          <= phase_next;
        debounce_start <= debounce_start_next;
        press_start    <= press_start_next;
        pending_event  <= pending_event_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ sim/key_debounce_short_long_press_top_tb.sv @@
module key_debounce_short_long_press_top_tb;
  import kdsl_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_WAIT_REL = 2'd3
  } key_phase_t;

  // indexes past the two real registers, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int PHASE_COUNT = 8;
  localparam int BEATS_PER_PHASE = 220;

  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  now_ms;
    logic               key_pressed;
    logic               typed;
    logic [EVENT_W-1:0] key_event;
    key_phase_t         fsm_phase;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 func = FUNC_TICK;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 key_pressed = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [EVENT_W-1:0]   key_event;
  logic [PHASE_W-1:0]   fsm_phase;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE_TIME;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow of the key qualifier
  key_phase_t         sh_phase = PH_IDLE;
  logic [TIME_W-1:0]  sh_debounce_start = '0;
  logic [TIME_W-1:0]  sh_press_start = '0;
  logic [EVENT_W-1:0] sh_latched_event = EV_NONE;
  logic [CFG_W-1:0]   sh_debounce_time = DEBOUNCE_TIME_RST;
  logic [CFG_W-1:0]   sh_long_press_time = LONG_PRESS_TIME_RST;

  result_t           expected_key_reports[$];
  int                errors = 0;
  int                beats_sent = 0;
  int                stall_left = 0;
  bit                src_idle_en = 1'b1;
  bit                sink_idle_en = 1'b1;
  bit                quiet_tail = 1'b0;
  logic [TIME_W-1:0] key_clock = '0;

  script_row_t opening_script [25] = '{
    '{FUNC_READ, 32'd0,          1'b0, 1'b1, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd0,          1'b0, 1'b1, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd100,        1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd110,        1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd120,        1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd500,        1'b0, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_READ, 32'd0,          1'b0, 1'b1, EV_SHORT, PH_IDLE},
    '{FUNC_READ, 32'hFFFF_FFFF,  1'b1, 1'b1, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd1000,       1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd1020,       1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd2020,       1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd3000,       1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd3001,       1'b0, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_READ, 32'd0,          1'b0, 1'b1, EV_LONG,  PH_IDLE},
    // debounce across the timestamp wrap
    '{FUNC_TICK, 32'hFFFF_FFF0,  1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd4,          1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd5,          1'b0, 1'b0, EV_NONE,  PH_IDLE},
    // time running backwards, long press overwrites the unread short one
    '{FUNC_TICK, 32'd16,         1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd15,         1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd14,         1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_READ, 32'hFFFF_FFFF,  1'b1, 1'b1, EV_LONG,  PH_WAIT_REL},
    '{FUNC_TICK, 32'hFFFF_FFFF,  1'b0, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd50,         1'b1, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_TICK, 32'd55,         1'b0, 1'b0, EV_NONE,  PH_IDLE},
    '{FUNC_READ, 32'd0,          1'b0, 1'b1, EV_NONE,  PH_IDLE}
  };

  key_debounce_short_long_press_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .now_ms(now_ms),
    .key_pressed(key_pressed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .key_event(key_event),
    .fsm_phase(fsm_phase),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic result_t qualify_key_beat(input logic f, input logic [TIME_W-1:0] t,
                                               input logic down);
    result_t r;
    logic [TIME_W-1:0] elapsed;
    r.key_event = EV_NONE;
    if (f == FUNC_READ) begin
      r.key_event = sh_latched_event;
      sh_latched_event = EV_NONE;
    end else begin
      case (sh_phase)
        PH_IDLE: begin
          if (down) begin
            sh_debounce_start = t;
            sh_phase = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          elapsed = t - sh_debounce_start;
          if (!down) begin
            sh_phase = PH_IDLE;
          end else if (elapsed >= {16'd0, sh_debounce_time}) begin
            sh_press_start = t;
            sh_phase = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          elapsed = t - sh_press_start;
          if (!down) begin
            sh_latched_event = EV_SHORT;
            sh_phase = PH_IDLE;
          end else if (elapsed >= {16'd0, sh_long_press_time}) begin
            sh_latched_event = EV_LONG;
            sh_phase = PH_WAIT_REL;
          end
        end
        default: begin
          if (!down) sh_phase = PH_IDLE;
        end
      endcase
    end
    r.fsm_phase = sh_phase;
    return r;
  endfunction

  // one input beat; on acceptance the expectation is queued
  task automatic send_beat(input logic f, input logic [TIME_W-1:0] t, input logic down,
                           input logic typed, input logic [EVENT_W-1:0] ev_typed,
                           input key_phase_t ph_typed);
    result_t r;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    now_ms <= t;
    key_pressed <= down;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = qualify_key_beat(f, t, down);
    if (typed) begin
      r.key_event = ev_typed;
      r.fsm_phase = ph_typed;
    end
    expected_key_reports.push_back(r);
    beats_sent++;
  endtask

  task automatic tick(input logic [TIME_W-1:0] t, input logic down);
    send_beat(FUNC_TICK, t, down, 1'b0, EV_NONE, PH_IDLE);
  endtask

  task automatic read_event();
    send_beat(FUNC_READ, $urandom, 1'($urandom_range(0, 1)), 1'b0, EV_NONE, PH_IDLE);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (expected_key_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_times(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold,
                               input bit poke_spare);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE_TIME;
    cfg_data <= debounce;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS_TIME;
    cfg_data <= hold;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE_2;
      cfg_data <= CFG_W'($urandom);
      @(posedge clk);
      cfg_index <= REG_SPARE_3;
      cfg_data <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sh_debounce_time = debounce;
    sh_long_press_time = hold;
  endtask

  // a press with random hold, occasional bounce, release and maybe a read
  task automatic press_session();
    int span;
    int downs;
    span = (int'(sh_debounce_time) + int'(sh_long_press_time)) / 5 + 2;
    case ($urandom_range(0, 15))
      0, 1:    key_clock = $urandom;
      2:       key_clock = 32'hFFFF_FFFF - $urandom_range(0, span * 4);
      default: key_clock = key_clock + $urandom_range(0, span);
    endcase
    if (!quiet_tail) begin
      src_idle_en = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
    end
    downs = $urandom_range(1, 14);
    repeat (downs) begin
      tick(key_clock, $urandom_range(0, 9) != 0);
      key_clock = key_clock + $urandom_range(0, span);
      if ($urandom_range(0, 11) == 0) read_event();
    end
    repeat ($urandom_range(1, 2)) begin
      tick(key_clock, 1'b0);
      key_clock = key_clock + $urandom_range(0, span);
    end
    if ($urandom_range(0, 1) == 0) read_event();
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_key_reports.size() == 0) begin
        $display("%0t unexpected beat: key_event %0d fsm_phase %0d", $time, key_event,
                 fsm_phase);
        errors++;
      end else begin
        want = expected_key_reports.pop_front();
        if (key_event !== want.key_event) begin
          $display("%0t key_event expected %0d actual %0d", $time, want.key_event, key_event);
          errors++;
        end
        if (fsm_phase !== want.fsm_phase) begin
          $display("%0t fsm_phase expected %0d actual %0d", $time, want.fsm_phase, fsm_phase);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] debounce_set [PHASE_COUNT];
    logic [CFG_W-1:0] hold_set [PHASE_COUNT];
    debounce_set = '{DEBOUNCE_TIME_RST, 16'd0, 16'd65535, 16'd0, 16'd1, 16'd0, 16'd65535, 16'd0};
    hold_set = '{LONG_PRESS_TIME_RST, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd0};
    debounce_set[3] = CFG_W'($urandom_range(1, 60));
    hold_set[3] = CFG_W'($urandom_range(1, 400));
    debounce_set[7] = CFG_W'($urandom_range(0, 100));
    hold_set[7] = CFG_W'($urandom_range(0, 600));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_script[i]) begin
      send_beat(opening_script[i].func, opening_script[i].now_ms, opening_script[i].key_pressed,
                opening_script[i].typed, opening_script[i].key_event,
                opening_script[i].fsm_phase);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_reports();
      if (p == PHASE_COUNT - 1) begin
        quiet_tail = 1'b1;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      program_times(debounce_set[p], hold_set[p], p == 2 || p == 5);
      while (beats_sent < 25 + (p + 1) * BEATS_PER_PHASE) begin
        if ($urandom_range(0, 4) != 0) begin
          press_session();
        end else begin
          // noise: any field value, any order
          repeat ($urandom_range(1, 4)) begin
            send_beat(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), 1'b0,
                      EV_NONE, PH_IDLE);
          end
        end
      end
    end

    drain_reports();
    if (errors == 0) begin
      $display("key_debounce_short_long_press_top_tb: clean");
    end else begin
      $display("key_debounce_short_long_press_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("key_debounce_short_long_press_top_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
design/kdsl_pkg.sv
design/kdsl_core.sv
design/key_debounce_short_long_press_top.sv
sim/key_debounce_short_long_press_top_tb.sv
